### hw/rtl/kss_pkg.sv
// ----------------------------------------------------------------------------
// kss_pkg
// Shared types and constants for the k-th smallest selection engine.
// ----------------------------------------------------------------------------
package kss_pkg;

    localparam int DATA_W           = 32;
    localparam int RANK_W           = 6;
    localparam int COUNT_W          = 7;
    localparam int OP_W             = 2;
    localparam int STATUS_W         = 2;
    localparam int DEFAULT_CAPACITY = 64;

    // Stream widths: payload rounded up to whole bytes.
    localparam int S_TDATA_W = ((DATA_W + RANK_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((DATA_W + COUNT_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic ins;    // place the broadcast sample
        logic load;   // copy stored value into the readout chain
        logic shift;  // move the readout chain one cell toward cell 0
    } t_cell_ctl;

    // What a cell hands to its right-hand neighbor.
    typedef struct packed {
        logic                     gt;     // valid and greater than the sample
        logic signed [DATA_W-1:0] value;
    } t_link;

endpackage

### hw/rtl/kss_cell.sv
// ----------------------------------------------------------------------------
// kss_cell
// One slot of the sorted store with its readout stage.
// ----------------------------------------------------------------------------
module kss_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
) (
    input  logic                             i_clk,
    input  kss_pkg::t_cell_ctl               i_ctl,
    input  logic signed [kss_pkg::DATA_W-1:0] i_sample,
    input  logic [CNT_W-1:0]                 i_count,
    input  kss_pkg::t_link                   i_left,
    input  logic signed [kss_pkg::DATA_W-1:0] i_rd_next,
    output kss_pkg::t_link                   o_link,
    output logic signed [kss_pkg::DATA_W-1:0] o_rd
);
    import kss_pkg::*;

    logic signed [DATA_W-1:0] r_value;
    logic signed [DATA_W-1:0] n_value;
    logic signed [DATA_W-1:0] r_rd;
    logic                     valid;
    logic                     gt;

    assign valid = i_count > CNT_W'(IDX);
    assign gt    = valid && (r_value > i_sample);

    assign o_link.gt    = gt;
    assign o_link.value = r_value;
    assign o_rd         = r_rd;

    // Keep a smaller-or-equal value; otherwise take the left value if it moves
    // right, else this is the insertion slot.
    always_comb begin
        priority if (valid && !gt) begin
            n_value = r_value;
        end else if (i_left.gt) begin
            n_value = i_left.value;
        end else begin
            n_value = i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            r_value <= n_value;
        end
        if (i_ctl.load) begin
            r_rd <= r_value;
        end else if (i_ctl.shift) begin
            r_rd <= i_rd_next;
        end
    end

endmodule

### hw/rtl/kth_smallest_select.sv
// ----------------------------------------------------------------------------
// kth_smallest_select
// Order-statistic engine over a row of insertion-sort cells.
// ----------------------------------------------------------------------------
// Each input beat is a command in tuser: clear empties the store, insert
// places a signed sample so the row stays in ascending order (a new sample
// lands after its equals), query returns the sample at a zero-based rank.
// Every command yields one output beat carrying value, status and the count
// after the command. Clear, insert, an unused code and an out-of-range query
// are answered straight from the idle state, so these beats can stream at one
// per cycle while the output side keeps up. An in-range query copies the whole
// row into a readout chain that shifts one cell toward cell 0 each cycle until
// the ranked sample is in cell 0; no new beat is taken meanwhile.
// Insert into a full store is dropped with status full; a query at a rank
// not below the count returns 0 with status range. The count is reported
// modulo 128. The store needs no clearing after reset.
// ----------------------------------------------------------------------------
module kth_smallest_select #(
    parameter int CAPACITY = kss_pkg::DEFAULT_CAPACITY
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave side
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [kss_pkg::S_TDATA_W-1:0]   i_s_tdata,  // sample[31:0], rank[37:32]
    input  logic [kss_pkg::OP_W-1:0]        i_s_tuser,  // op[1:0]
    // master side
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [kss_pkg::M_TDATA_W-1:0]   o_m_tdata,  // value[31:0], count[38:32]
    output logic [kss_pkg::STATUS_W-1:0]    o_m_tuser   // status[1:0]
);
    import kss_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > RANK_W) ? CNT_W : RANK_W;

    // Control state
    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_out_valid, n_out_valid;
    // Payload
    logic [RANK_W-1:0]        r_left, n_left;
    logic signed [DATA_W-1:0] r_out_value, n_out_value;
    t_status                  r_out_status, n_out_status;
    logic [COUNT_W-1:0]       r_out_count, n_out_count;

    t_cell_ctl                ctl;
    t_op                      in_op;
    logic signed [DATA_W-1:0] in_sample;
    logic [RANK_W-1:0]        in_rank;
    logic                     in_acc;
    logic                     out_free;
    logic                     full;
    logic                     rank_ok;

    t_link                    w_link [0:CAPACITY-1];
    logic signed [DATA_W-1:0] w_rd   [0:CAPACITY];

    // Unpack the input beat
    assign in_op     = t_op'(i_s_tuser);
    assign in_sample = i_s_tdata[DATA_W-1:0];
    assign in_rank   = i_s_tdata[DATA_W+RANK_W-1:DATA_W];

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && out_free;
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign full       = r_count >= CNT_W'(CAPACITY);
    assign rank_ok    = CMP_W'(in_rank) < CMP_W'(r_count);

    // Row of cells: the sample is broadcast, each cell looks at its left
    // neighbor to decide whether to shift right on insert.
    assign w_rd[CAPACITY] = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_link left;
        if (g == 0) begin : g_first
            assign left = '0;
        end else begin : g_rest
            assign left = w_link[g-1];
        end
        kss_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (ctl),
            .i_sample  (in_sample),
            .i_count   (r_count),
            .i_left    (left),
            .i_rd_next (w_rd[g+1]),
            .o_link    (w_link[g]),
            .o_rd      (w_rd[g])
        );
    end

    // Sequencer: next state, store controls and output beat
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_left       = r_left;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        ctl          = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = '0;
                    n_out_status = ST_OK;
                    n_out_count  = COUNT_W'(r_count);
                    unique case (in_op)
                        OP_CLEAR: begin
                            n_count     = '0;
                            n_out_count = '0;
                        end
                        OP_INSERT: begin
                            if (full) begin
                                n_out_status = ST_FULL;
                            end else begin
                                ctl.ins     = 1'b1;
                                n_count     = CNT_W'(r_count + 1'b1);
                                n_out_count = COUNT_W'(CNT_W'(r_count + 1'b1));
                            end
                        end
                        OP_QUERY: begin
                            if (rank_ok) begin
                                // hold the beat until the chain delivers it
                                ctl.load    = 1'b1;
                                n_left      = in_rank;
                                n_out_valid = 1'b0;
                                n_state     = S_READ;
                            end else begin
                                n_out_status = ST_RANGE;
                            end
                        end
                        OP_NOP: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                if (r_left == '0) begin
                    if (out_free) begin
                        n_out_valid  = 1'b1;
                        n_out_value  = w_rd[0];
                        n_out_status = ST_OK;
                        n_out_count  = COUNT_W'(r_count);
                        n_state      = S_IDLE;
                    end
                end else begin
                    ctl.shift = 1'b1;
                    n_left    = r_left - 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left       <= n_left;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
    end

    // Pack the output beat
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_TDATA_W - DATA_W - COUNT_W){1'b0}}, r_out_count, r_out_value};
    assign o_m_tuser  = r_out_status;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("stored count exceeds capacity");

    a_read_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !r_out_valid)
        else $error("output register busy during readout");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && in_op == OP_INSERT && full)
            |=> (r_out_valid && r_out_status == ST_FULL && $stable(r_count)))
        else $error("insert into full store not flagged");

    a_sorted_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CMP_W'(r_count) >= CMP_W'(2)) |-> (w_link[0].value <= w_link[1].value))
        else $error("first two stored samples out of order");

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the k-th smallest selection engine.
// ----------------------------------------------------------------------------
// Sends clear, insert, query and unused commands over the slave stream. For
// every accepted beat, an in-order sorted sample list predicts the result.
// Each result beat is checked field by field against the oldest prediction.
// Both sides idle at random, and one long receiver hold-off lets the engine
// fill up and stall its input. The final stretch runs with no idling.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import kss_pkg::*;

    localparam int CAPACITY     = DEFAULT_CAPACITY;
    localparam int LONG_HOLD    = 150;   // receiver hold-off, in cycles
    localparam int DRAIN_CYCLES = 100;   // settle margin after the last result, in cycles

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        t_status                  status;
        logic [COUNT_W-1:0]       count;
    } t_select_result;

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [S_TDATA_W-1:0]   i_s_tdata  = '0;    // sample[31:0], rank[37:32]
    logic [OP_W-1:0]        i_s_tuser  = '0;    // op[1:0]
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   o_m_tdata;          // value[31:0], count[38:32]
    logic [STATUS_W-1:0]    o_m_tuser;          // status[1:0]

    // Predicted store contents, ascending, and results still owed by the engine.
    logic signed [DATA_W-1:0] sorted_samples[$];
    t_select_result           pending_results[$];

    int  fail_count = 0;
    bit  idle_en    = 1'b1;
    bit  hold_req   = 1'b0;

    kth_smallest_select #(
        .CAPACITY (CAPACITY)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #6 i_clk = ~i_clk;

    // Apply one command to the predicted store and return the result it owes.
    function automatic t_select_result predict_select(t_op op, logic signed [DATA_W-1:0] smp,
                                                      logic [RANK_W-1:0] rk);
        t_select_result r;
        int pos;
        r.value  = '0;
        r.status = ST_OK;
        case (op)
            OP_CLEAR: begin
                sorted_samples.delete();
            end
            OP_INSERT: begin
                if (sorted_samples.size() >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    // a new sample lands after all of its equals
                    pos = 0;
                    while (pos < sorted_samples.size() && sorted_samples[pos] <= smp)
                        pos++;
                    sorted_samples.insert(pos, smp);
                end
            end
            OP_QUERY: begin
                if (rk < sorted_samples.size())
                    r.value = sorted_samples[rk];
                else
                    r.status = ST_RANGE;
            end
            default: begin
            end
        endcase
        r.count = COUNT_W'(sorted_samples.size());
        return r;
    endfunction

    // Mix full-range values with a narrow band (forces equals) and the extremes.
    function automatic logic signed [DATA_W-1:0] random_sample();
        case ($urandom_range(0, 3))
            0: return $signed(32'($urandom_range(0, 8))) - 4;
            1: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return '0;
                    default: return -1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // Mostly ranks inside the store, sometimes anywhere in the field.
    function automatic logic [RANK_W-1:0] random_rank();
        if (sorted_samples.size() > 0 && $urandom_range(0, 4) != 0)
            return RANK_W'($urandom_range(0, sorted_samples.size() - 1));
        return RANK_W'($urandom);
    endfunction

    // Offer one beat, hold it until accepted, then book its prediction.
    task automatic drive_command(t_op op, logic signed [DATA_W-1:0] smp, logic [RANK_W-1:0] rk);
        int unsigned gap;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= S_TDATA_W'({rk, smp});
        i_s_tuser  <= op;
        @(posedge i_clk);
        while (o_s_tready !== 1'b1) @(posedge i_clk);
        pending_results.insert(pending_results.size(), predict_select(op, smp, rk));
    endtask

    // Load-then-query bursts with random content, plus some noise commands.
    task automatic run_random_commands(int unsigned n_items);
        int unsigned sent;
        int unsigned n_ins;
        int unsigned n_qry;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                drive_command(t_op'($urandom_range(0, 3)), $urandom, RANK_W'($urandom));
                sent++;
            end else begin
                // skip the clear now and then so the store keeps growing
                if ($urandom_range(0, 4) != 0) begin
                    drive_command(OP_CLEAR, $urandom, RANK_W'($urandom));
                    sent++;
                end
                n_ins = ($urandom_range(0, 3) == 0) ? $urandom_range(1, CAPACITY + 6)
                                                    : $urandom_range(1, 16);
                repeat (n_ins) begin
                    drive_command(OP_INSERT, random_sample(), RANK_W'($urandom));
                    sent++;
                end
                n_qry = $urandom_range(1, 12);
                repeat (n_qry) begin
                    drive_command(OP_QUERY, $urandom, random_rank());
                    sent++;
                end
            end
        end
    endtask

    task automatic test_directed_cases();
        drive_command(OP_CLEAR, '0, '0);
        drive_command(OP_QUERY, '0, '0);                    // empty store: out of range
        drive_command(OP_INSERT, 32'sh7fff_ffff, '0);
        drive_command(OP_INSERT, 32'sh8000_0000, '0);
        drive_command(OP_INSERT, 0, '0);
        drive_command(OP_INSERT, -1, '1);
        drive_command(OP_INSERT, 1, '0);
        drive_command(OP_INSERT, 5, '0);
        drive_command(OP_INSERT, 5, '0);                    // equal values all kept
        drive_command(OP_QUERY, '0, 6'd0);
        drive_command(OP_QUERY, '0, 6'd3);
        drive_command(OP_QUERY, '0, 6'd5);
        drive_command(OP_QUERY, '1, 6'd6);                  // last valid rank
        drive_command(OP_QUERY, '0, 6'd7);                  // rank equal to count
        drive_command(OP_QUERY, '0, 6'd63);
        drive_command(OP_NOP, '1, '1);                      // unused code: no change
        drive_command(OP_NOP, '0, '0);
        drive_command(OP_QUERY, '0, 6'd2);
        drive_command(OP_CLEAR, '1, '1);
        drive_command(OP_QUERY, '0, 6'd0);
        drive_command(OP_INSERT, -7, '0);
        drive_command(OP_QUERY, '0, 6'd0);
    endtask

    task automatic test_full_store();
        drive_command(OP_CLEAR, '0, '0);
        repeat (CAPACITY) drive_command(OP_INSERT, random_sample(), RANK_W'($urandom));
        drive_command(OP_INSERT, 32'sh8000_0000, '0);       // full: dropped
        drive_command(OP_INSERT, random_sample(), '1);
        drive_command(OP_QUERY, '0, 6'd63);                 // deepest readout
        drive_command(OP_QUERY, '0, 6'd0);
        repeat (6) drive_command(OP_QUERY, $urandom, RANK_W'($urandom));
        drive_command(OP_NOP, $urandom, RANK_W'($urandom));
        drive_command(OP_CLEAR, '0, '0);
    endtask

    task automatic test_random_loads();
        run_random_commands(1450);
    endtask

    // Receiver stops for a long stretch; keep offering so the input backs up.
    task automatic test_output_backpressure();
        hold_req = 1'b1;
        drive_command(OP_CLEAR, '0, '0);
        repeat (30) drive_command(OP_INSERT, random_sample(), RANK_W'($urandom));
        repeat (30) drive_command(OP_QUERY, $urandom, random_rank());
    endtask

    task automatic test_full_rate_tail();
        idle_en = 1'b0;
        run_random_commands(250);
    endtask

    // Result side: check each accepted beat, then pick the next tready value.
    initial begin
        int unsigned stall_left;
        int unsigned hold_left;
        t_select_result exp_r;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge i_clk);
            if (o_m_tvalid === 1'b1 && i_m_tready === 1'b1) begin
                if (pending_results.size() == 0) begin
                    $error("result beat with nothing owed: value %0d status %0d count %0d",
                           $signed(o_m_tdata[DATA_W-1:0]), o_m_tuser,
                           o_m_tdata[DATA_W +: COUNT_W]);
                    fail_count++;
                end else begin
                    exp_r = pending_results.pop_front();
                    if (o_m_tdata[DATA_W-1:0] !== exp_r.value) begin
                        $error("value: expected %0d, got %0d", exp_r.value,
                               $signed(o_m_tdata[DATA_W-1:0]));
                        fail_count++;
                    end
                    if (o_m_tuser !== exp_r.status) begin
                        $error("status: expected %0d, got %0d", exp_r.status, o_m_tuser);
                        fail_count++;
                    end
                    if (o_m_tdata[DATA_W +: COUNT_W] !== exp_r.count) begin
                        $error("count: expected %0d, got %0d", exp_r.count,
                               o_m_tdata[DATA_W +: COUNT_W]);
                        fail_count++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD - 1;
                i_m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 7) - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_full_store();
        test_random_loads();
        test_output_backpressure();
        test_full_rate_tail();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end

endmodule

### kth_smallest_select.f
hw/rtl/kss_pkg.sv
hw/rtl/kss_cell.sv
hw/rtl/kth_smallest_select.sv
tb/sv/tb_top.sv
